// ===== rtl/keypad_code_alarm_lock_unit_defines.svh =====
// Assertion macros shared by the lock unit.
`ifndef KEYPAD_CODE_ALARM_LOCK_UNIT_DEFINES_SVH
`define KEYPAD_CODE_ALARM_LOCK_UNIT_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define KCAL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lock unit check failed");

// Check that a condition implies a consequence in the next cycle.
`define KCAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lock unit check failed");

`endif

// ===== rtl/kcal_pkg.sv =====
package kcal_pkg;

   // Entry buffer geometry
   localparam int CODE_DIGITS = 6;
   localparam int COUNT_W     = $clog2(CODE_DIGITS + 1);

   // Key codes
   localparam logic [7:0] KEY_STAR = 8'd42;
   localparam logic [7:0] KEY_HASH = 8'd35;

   // Accepted code lengths
   localparam logic [COUNT_W-1:0] SHORT_CODE = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] LONG_CODE  = COUNT_W'(6);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CODE_DIGITS);

   localparam logic [7:0] COUNTDOWN_RESET = 8'd60;

   // Request kinds
   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Event codes
   localparam logic [3:0] EV_NONE        = 4'd0;
   localparam logic [3:0] EV_STORED      = 4'd1;
   localparam logic [3:0] EV_OVERFLOW    = 4'd2;
   localparam logic [3:0] EV_USER_CLEAR  = 4'd3;
   localparam logic [3:0] EV_ARMED       = 4'd4;
   localparam logic [3:0] EV_DISARMED    = 4'd5;
   localparam logic [3:0] EV_WRONG       = 4'd6;
   localparam logic [3:0] EV_BAD_LENGTH  = 4'd7;
   localparam logic [3:0] EV_SIREN       = 4'd8;
   localparam logic [3:0] EV_COUNT_START = 4'd9;

   typedef logic [CODE_DIGITS-1:0][7:0] code_type;

   typedef struct packed {
      code_type           entry_chars;
      logic [COUNT_W-1:0] entry_count;
      code_type           secret_chars;
      logic [COUNT_W-1:0] secret_count;
      logic               armed;
      logic               siren;
      logic               counting;
      logic [7:0]         seconds_left;
   } lock_state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] key_char;
      logic       motion;
   } item_type;

   typedef struct packed {
      logic       armed;
      logic       siren;
      logic [7:0] countdown;
      logic [2:0] entry_length;
      logic [3:0] event_res;
   } result_type;

endpackage

// ===== rtl/kcal_step.sv =====
module kcal_step (
   input  kcal_pkg::lock_state_type state_cur,
   input  kcal_pkg::item_type       item,
   input  logic [7:0]               countdown_seconds,
   output kcal_pkg::lock_state_type state_nxt,
   output kcal_pkg::result_type     result
);

   logic       mismatch;
   logic       codes_match;
   logic       length_ok;
   logic [3:0] event_code;

   // Compare entry against stored code below the entry count
   always_comb begin
      mismatch = 1'b0;
      for (int i = 0; i < kcal_pkg::CODE_DIGITS; i++) begin
         if ((i < int'(state_cur.entry_count)) &&
             (state_cur.entry_chars[i] != state_cur.secret_chars[i])) begin
            mismatch = 1'b1;
         end
      end
   end

   assign codes_match = (state_cur.entry_count == state_cur.secret_count) && !mismatch;
   assign length_ok   = (state_cur.entry_count == kcal_pkg::SHORT_CODE) ||
                        (state_cur.entry_count == kcal_pkg::LONG_CODE);

   // Advance the lock state by one request
   always_comb begin
      state_nxt  = state_cur;
      event_code = kcal_pkg::EV_NONE;
      if (item.kind == kcal_pkg::KIND_KEY) begin
         if (item.key_char == kcal_pkg::KEY_STAR) begin
            state_nxt.entry_count = '0;
            event_code            = kcal_pkg::EV_USER_CLEAR;
         end else if (item.key_char == kcal_pkg::KEY_HASH) begin
            state_nxt.entry_count = '0;
            if (!length_ok) begin
               event_code = kcal_pkg::EV_BAD_LENGTH;
            end else if (!state_cur.armed) begin
               state_nxt.secret_chars = state_cur.entry_chars;
               state_nxt.secret_count = state_cur.entry_count;
               state_nxt.armed        = 1'b1;
               event_code             = kcal_pkg::EV_ARMED;
            end else if (codes_match) begin
               state_nxt.armed        = 1'b0;
               state_nxt.siren        = 1'b0;
               state_nxt.counting     = 1'b0;
               state_nxt.seconds_left = '0;
               event_code             = kcal_pkg::EV_DISARMED;
            end else begin
               event_code = kcal_pkg::EV_WRONG;
            end
         end else if (state_cur.entry_count < kcal_pkg::FULL_COUNT) begin
            for (int i = 0; i < kcal_pkg::CODE_DIGITS; i++) begin
               if (state_cur.entry_count == kcal_pkg::COUNT_W'(i)) begin
                  state_nxt.entry_chars[i] = item.key_char;
               end
            end
            state_nxt.entry_count = state_cur.entry_count + 1'b1;
            event_code            = kcal_pkg::EV_STORED;
         end else begin
            state_nxt.entry_count = '0;
            event_code            = kcal_pkg::EV_OVERFLOW;
         end
      end else begin
         if (state_cur.counting) begin
            if (state_cur.seconds_left != '0) begin
               state_nxt.seconds_left = state_cur.seconds_left - 1'b1;
            end else begin
               state_nxt.counting = 1'b0;
               if (item.motion) begin
                  state_nxt.siren = 1'b1;
                  event_code      = kcal_pkg::EV_SIREN;
               end
            end
         end else if (state_cur.armed && item.motion && !state_cur.siren) begin
            state_nxt.counting     = 1'b1;
            state_nxt.seconds_left = countdown_seconds;
            event_code             = kcal_pkg::EV_COUNT_START;
         end
      end
   end

   // Report the state after the request
   always_comb begin
      result.armed        = state_nxt.armed;
      result.siren        = state_nxt.siren;
      result.countdown    = state_nxt.counting ? state_nxt.seconds_left : 8'd0;
      result.entry_length = 3'(state_nxt.entry_count);
      result.event_res    = event_code;
   end

endmodule

// ===== rtl/keypad_code_alarm_lock_unit.sv =====
// Keypad alarm lock.
// Request channel (req_valid/req_stall): req_kind selects a key press (0) or a
// one-second tick (1); req_key_char carries the key on presses, req_motion the
// sensor level on ticks. Every request yields exactly one response on the
// rsp_valid/rsp_stall channel with armed, siren, countdown, entry length and
// an event code, showing the lock state after that request.
// csr_write_enable/csr_write_data load the countdown length in seconds; write
// it only while no request is in flight.
// A request accepted into the input register is loaded into the response
// register once that register is free, and rsp_valid rises with that load.
// Throughput is one request per cycle while rsp_stall is low, set by that
// single combinational step.
// Reset: lock disarmed, siren off, countdown stopped, entry empty, countdown
// length 60, both channels empty.
// When rsp_stall is high the response holds; the input register still takes
// one more request, and req_stall rises only once that register is also full.
`include "keypad_code_alarm_lock_unit_defines.svh"

module keypad_code_alarm_lock_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_key_char,
   input  logic       req_motion,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_armed,
   output logic       rsp_siren,
   output logic [7:0] rsp_countdown,
   output logic [2:0] rsp_entry_length,
   output logic [3:0] rsp_event_res,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic                     req_accept;
   logic                     advance;
   logic                     in_vld_ff;
   logic                     in_vld_in;
   kcal_pkg::item_type       item_ff;
   logic                     rsp_vld_ff;
   logic                     rsp_vld_in;
   kcal_pkg::result_type     rsp_ff;
   kcal_pkg::result_type     rsp_in;
   kcal_pkg::lock_state_type state_ff;
   kcal_pkg::lock_state_type state_in;
   logic [7:0]               countdown_seconds_ff;

   // Handshake: move the held request into the response register when free
   assign advance    = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign in_vld_in  = req_accept || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && rsp_stall);

   // Hold the countdown length
   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_seconds_ff <= kcal_pkg::COUNTDOWN_RESET;
      end else if (csr_write_enable) begin
         countdown_seconds_ff <= csr_write_data;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.kind     <= req_kind;
         item_ff.key_char <= req_key_char;
         item_ff.motion   <= req_motion;
      end
   end

   kcal_step u_step (
      .state_cur         (state_ff),
      .item              (item_ff),
      .countdown_seconds (countdown_seconds_ff),
      .state_nxt         (state_in),
      .result            (rsp_in)
   );

   // Update lock state; code bytes need no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.entry_count  <= '0;
         state_ff.secret_count <= '0;
         state_ff.armed        <= 1'b0;
         state_ff.siren        <= 1'b0;
         state_ff.counting     <= 1'b0;
         state_ff.seconds_left <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_armed        = rsp_ff.armed;
   assign rsp_siren        = rsp_ff.siren;
   assign rsp_countdown    = rsp_ff.countdown;
   assign rsp_entry_length = rsp_ff.entry_length;
   assign rsp_event_res    = rsp_ff.event_res;

   // A running countdown and the siren only exist while armed
   `KCAL_ASSERT_SAME(a_countdown_armed, clock, reset,
      rsp_valid && (rsp_countdown != 8'd0), rsp_armed)
   `KCAL_ASSERT_SAME(a_siren_armed, clock, reset, rsp_valid && rsp_siren, rsp_armed)
   // A stored character leaves a nonempty entry
   `KCAL_ASSERT_SAME(a_stored_len, clock, reset,
      rsp_valid && (rsp_event_res == kcal_pkg::EV_STORED), rsp_entry_length != 3'd0)
   // Stall the request side only with a held request
   `KCAL_ASSERT_SAME(a_stall_held, clock, reset, req_stall, in_vld_ff && rsp_vld_ff)
   // A stalled response is followed by a valid response
   `KCAL_ASSERT_NEXT(a_rsp_kept, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned PHASE_ITEMS   = 75;
   localparam int unsigned MAX_REPORTS   = 10;

   // Track lock state and hold the expected responses in arrival order.
   class lock_scoreboard;
      logic [7:0]                   countdown_len;
      logic [7:0]                   entry_buf [kcal_pkg::CODE_DIGITS];
      logic [kcal_pkg::COUNT_W-1:0] entry_len;
      logic [7:0]                   code_buf [kcal_pkg::CODE_DIGITS];
      logic [kcal_pkg::COUNT_W-1:0] code_len;
      bit                           armed;
      bit                           siren;
      bit                           counting;
      logic [7:0]                   secs_left;
      kcal_pkg::result_type         expected_q [$];
      int unsigned                  mismatches;

      function new();
         countdown_len = kcal_pkg::COUNTDOWN_RESET;
         entry_len     = '0;
         code_len      = '0;
         armed         = 1'b0;
         siren         = 1'b0;
         counting      = 1'b0;
         secs_left     = '0;
         mismatches    = 0;
         foreach (entry_buf[i]) begin
            entry_buf[i] = '0;
            code_buf[i]  = '0;
         end
      endfunction

      function void set_countdown(logic [7:0] value);
         countdown_len = value;
      endfunction

      function bit code_matches();
         if (entry_len != code_len)
            return 1'b0;
         for (int i = 0; i < entry_len; i++)
            if (entry_buf[i] != code_buf[i])
               return 1'b0;
         return 1'b1;
      endfunction

      function logic [3:0] press_key(logic [7:0] ch);
         logic [3:0] ev;
         if (ch == kcal_pkg::KEY_STAR) begin
            entry_len = '0;
            ev = kcal_pkg::EV_USER_CLEAR;
         end else if (ch == kcal_pkg::KEY_HASH) begin
            if (entry_len == kcal_pkg::SHORT_CODE || entry_len == kcal_pkg::LONG_CODE) begin
               if (!armed) begin
                  for (int i = 0; i < entry_len; i++)
                     code_buf[i] = entry_buf[i];
                  code_len = entry_len;
                  armed    = 1'b1;
                  ev       = kcal_pkg::EV_ARMED;
               end else if (code_matches()) begin
                  armed     = 1'b0;
                  siren     = 1'b0;
                  counting  = 1'b0;
                  secs_left = '0;
                  ev        = kcal_pkg::EV_DISARMED;
               end else begin
                  ev = kcal_pkg::EV_WRONG;
               end
            end else begin
               ev = kcal_pkg::EV_BAD_LENGTH;
            end
            entry_len = '0;
         end else if (entry_len < kcal_pkg::FULL_COUNT) begin
            entry_buf[entry_len] = ch;
            entry_len++;
            ev = kcal_pkg::EV_STORED;
         end else begin
            // full entry: drop the key and clear
            entry_len = '0;
            ev = kcal_pkg::EV_OVERFLOW;
         end
         return ev;
      endfunction

      function logic [3:0] second_tick(logic motion);
         if (counting) begin
            if (secs_left > 0) begin
               secs_left--;
               return kcal_pkg::EV_NONE;
            end
            counting = 1'b0;
            if (motion) begin
               siren = 1'b1;
               return kcal_pkg::EV_SIREN;
            end
            return kcal_pkg::EV_NONE;
         end
         if (armed && motion && !siren) begin
            counting  = 1'b1;
            secs_left = countdown_len;
            return kcal_pkg::EV_COUNT_START;
         end
         return kcal_pkg::EV_NONE;
      endfunction

      // Advance the lock on one accepted request and queue its response.
      function void note_request(kcal_pkg::item_type req);
         kcal_pkg::result_type want;
         if (req.kind == kcal_pkg::KIND_KEY)
            want.event_res = press_key(req.key_char);
         else
            want.event_res = second_tick(req.motion);
         want.armed        = armed;
         want.siren        = siren;
         want.countdown    = counting ? secs_left : 8'd0;
         want.entry_length = entry_len;
         expected_q.push_back(want);
      endfunction

      function void check_response(kcal_pkg::result_type got);
         kcal_pkg::result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response at %0t: armed %0d siren %0d countdown %0d",
                        $realtime, got.armed, got.siren, got.countdown);
            return;
         end
         want = expected_q.pop_front();
         if (got.armed !== want.armed || got.siren !== want.siren
             || got.countdown !== want.countdown
             || got.entry_length !== want.entry_length
             || got.event_res !== want.event_res) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display({"response mismatch at %0t (expected/actual): armed %0d/%0d ",
                         "siren %0d/%0d countdown %0d/%0d length %0d/%0d event %0d/%0d"},
                        $realtime, want.armed, got.armed, want.siren, got.siren,
                        want.countdown, got.countdown, want.entry_length,
                        got.entry_length, want.event_res, got.event_res);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic       req_kind         = kcal_pkg::KIND_KEY;
   logic [7:0] req_key_char     = 8'd0;
   logic       req_motion       = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic       rsp_armed;
   logic       rsp_siren;
   logic [7:0] rsp_countdown;
   logic [2:0] rsp_entry_length;
   logic [3:0] rsp_event_res;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data   = 8'd0;

   lock_scoreboard sb = new();

   bit          sender_quiet   = 1'b0;
   bit          receiver_quiet = 1'b0;
   int unsigned hold_left      = 0;
   int unsigned phase_items    = 0;
   int unsigned cycle_count    = 0;

   keypad_code_alarm_lock_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_key_char     (req_key_char),
      .req_motion       (req_motion),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_armed        (rsp_armed),
      .rsp_siren        (rsp_siren),
      .rsp_countdown    (rsp_countdown),
      .rsp_entry_length (rsp_entry_length),
      .rsp_event_res    (rsp_event_res),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Record accepted requests and check accepted responses.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(kcal_pkg::item_type'{kind: req_kind, key_char: req_key_char,
                                              motion: req_motion});
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(kcal_pkg::result_type'{armed: rsp_armed, siren: rsp_siren,
                                                  countdown: rsp_countdown,
                                                  entry_length: rsp_entry_length,
                                                  event_res: rsp_event_res});
   end

   // Stall responses for a random stretch after each one, or for a long hold.
   initial begin : response_side
      int unsigned wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            wait_left = receiver_quiet ? 0 : $urandom_range(0, 15);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request after a random gap and hold it until taken.
   task automatic send_request(input logic kind, input logic [7:0] ch, input logic mo);
      int unsigned gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_key_char <= ch;
      req_motion   <= mo;
      do @(posedge clock); while (req_stall);
      phase_items++;
   endtask

   task automatic press(input logic [7:0] ch);
      send_request(kcal_pkg::KIND_KEY, ch, 1'($urandom_range(0, 1)));
   endtask

   task automatic tick(input logic mo);
      send_request(kcal_pkg::KIND_TICK, 8'($urandom_range(0, 255)), mo);
   endtask

   // Drop valid and wait until every response is back and the pipe is empty.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_countdown(input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_countdown(value);
   endtask

   function automatic logic [7:0] code_char();
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255));
      while (ch == kcal_pkg::KEY_STAR || ch == kcal_pkg::KEY_HASH);
      return ch;
   endfunction

   task automatic run_directed();
      logic [7:0] fill_keys [7] = '{8'h00, 8'hFF, 8'h31, 8'h32, 8'h33, 8'h34, 8'h7E};
      logic [7:0] pin_keys [4]  = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
      // motion while disarmed does nothing
      tick(1'b1);
      // fill the entry, then overflow it
      foreach (fill_keys[i]) press(fill_keys[i]);
      press(kcal_pkg::KEY_STAR);
      press(kcal_pkg::KEY_HASH);
      // arm with a short code
      foreach (pin_keys[i]) press(pin_keys[i]);
      press(kcal_pkg::KEY_HASH);
      // start a countdown at the reset length, let one second pass
      tick(1'b1);
      tick(1'b0);
      // disarm mid-countdown
      foreach (pin_keys[i]) press(pin_keys[i]);
      press(kcal_pkg::KEY_HASH);
   endtask

   task automatic random_scenario();
      int unsigned pick;
      int unsigned n;
      logic [7:0]  code [8];
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         // submit a code: mostly the stored one when armed
         if (sb.armed && $urandom_range(0, 2) != 0) begin
            n = sb.code_len;
            for (int i = 0; i < n; i++) code[i] = sb.code_buf[i];
            if ($urandom_range(0, 3) == 0)
               code[$urandom_range(0, n - 1)] ^= 8'($urandom_range(1, 255));
         end else begin
            if ($urandom_range(0, 5) == 0)
               n = $urandom_range(0, 7);
            else
               n = $urandom_range(0, 1) ? 4 : 6;
            for (int i = 0; i < n; i++) code[i] = code_char();
         end
         for (int i = 0; i < n; i++) press(code[i]);
         press(($urandom_range(0, 9) == 0) ? kcal_pkg::KEY_STAR : kcal_pkg::KEY_HASH);
      end else if (pick < 75) begin
         // a run of seconds, motion mostly present
         n = $urandom_range(1, 10);
         repeat (n) tick(1'($urandom_range(0, 3) != 0));
      end else if (pick < 85) begin
         // abandon a partial entry
         n = $urandom_range(0, 6);
         repeat (n) press(code_char());
         press(kcal_pkg::KEY_STAR);
      end else begin
         send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
      end
   endtask

   initial begin : stimulus
      logic [7:0] phase_len [4] = '{8'd0, 8'd255, 8'd3, 8'd1};
      bit         hold_done;
      bit         pause_done;
      int unsigned errors;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (int p = 0; p < 8; p++) begin
         drain_responses();
         if (p < 4)
            write_countdown(phase_len[p]);
         else
            write_countdown(8'($urandom_range(1, 8)));
         sender_quiet   = (p == 5);
         receiver_quiet = (p == 5);
         phase_items    = 0;
         while (phase_items < PHASE_ITEMS) begin
            // long receiver hold with back-to-back requests behind it
            if (p == 2 && !hold_done && phase_items >= 20) begin
               hold_left    = 200;
               sender_quiet = 1'b1;
               hold_done    = 1'b1;
            end
            if (p == 2 && phase_items >= 50)
               sender_quiet = 1'b0;
            if (p == 3 && !pause_done && phase_items >= 40) begin
               drain_responses();
               pause_done = 1'b1;
            end
            random_scenario();
         end
      end

      drain_responses();
      errors = sb.mismatches + sb.pending();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
